>>> design/erc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package erc_pkg;

  localparam int unsigned QuotBits = 17;

  // register indexes on the configuration port
  localparam logic [2:0] RegSnowTemp     = 3'd0;
  localparam logic [2:0] RegRainSnowTemp = 3'd1;
  localparam logic [2:0] RegFrozenTemp   = 3'd2;
  localparam logic [2:0] RegFrozenFrac   = 3'd3;
  localparam logic [2:0] RegCellCount    = 3'd4;

  localparam logic CmdInit = 1'b0;

  // what travels with an item from the compute stages through the divider
  typedef struct packed {
    logic [31:0] excess;
    logic [30:0] infil;
    logic [30:0] moist;
    logic        en;
    logic [30:0] divisor;
  } erc_side_t;

endpackage
`default_nettype wire

>>> design/excess_runoff_cell_step_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Per-cell infiltration step. Items flow through a 21-stage pipeline (input
// register with moisture read, two compute stages, a 17-stage divider that
// forms the moisture increment one quotient bit per stage, output register)
// and one item can enter per cycle unless an output stall or the hazard below
// holds it. The moisture store has one read and one write port; an item whose
// cell is still in flight waits at the input until that cell's moisture is
// written back, which only happens when cell_count is below the pipeline depth.
// The store holds garbage until each cell has seen an init transaction.
module excess_runoff_cell_step_top
  import erc_pkg::*;
#(
  parameter int unsigned MAX_CELLS = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        command_i,
  input  wire logic [30:0] net_precip_i,
  input  wire logic signed [31:0] temp_max_i,
  input  wire logic signed [31:0] temp_min_i,
  input  wire logic [30:0] depression_storage_i,
  input  wire logic [30:0] snow_accum_i,
  input  wire logic [30:0] snow_melt_i,
  input  wire logic signed [31:0] soil_temp_i,
  input  wire logic [16:0] porosity_i,
  input  wire logic [30:0] root_depth_i,
  input  wire logic [16:0] init_fraction_i,
  input  wire logic [16:0] field_capacity_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [9:0]       cell_index_o,
  output logic signed [31:0] excess_precip_o,
  output logic [30:0]      infiltration_o,
  output logic [30:0]      soil_moisture_o
);

  localparam int unsigned IDX_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

  // configuration
  logic [31:0] snow_temp_q, rain_snow_temp_q, frozen_temp_q;
  logic [16:0] frozen_fraction_q;
  logic [10:0] cell_count_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snow_temp_q       <= 32'd0;
      rain_snow_temp_q  <= 32'd65536;
      frozen_temp_q     <= 32'hFFFB_0000;
      frozen_fraction_q <= 17'd32768;
      cell_count_q      <= 11'd1024;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        RegSnowTemp:     snow_temp_q       <= pwdata;
        RegRainSnowTemp: rain_snow_temp_q  <= pwdata;
        RegFrozenTemp:   frozen_temp_q     <= pwdata;
        RegFrozenFrac:   frozen_fraction_q <= pwdata[16:0];
        RegCellCount:    cell_count_q      <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      RegSnowTemp:     prdata = snow_temp_q;
      RegRainSnowTemp: prdata = rain_snow_temp_q;
      RegFrozenTemp:   prdata = frozen_temp_q;
      RegFrozenFrac:   prdata = 32'(frozen_fraction_q);
      RegCellCount:    prdata = 32'(cell_count_q);
      default:         prdata = 32'd0;
    endcase
  end

  // pipeline control
  logic             adv;
  logic             hazard;
  logic             accept;
  logic             calc_hit, div_hit, a_hit;
  logic [IDX_W-1:0] counter_q;
  logic [16:0]      next_cnt;

  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv || hazard;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    next_cnt = 17'(counter_q) + 17'd1;
    if ((next_cnt >= 17'(cell_count_q)) || (next_cnt >= 17'(MAX_CELLS))) begin
      next_cnt = 17'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q <= '0;
    end else if (accept) begin
      counter_q <= next_cnt[IDX_W-1:0];
    end
  end

  // stage A: input register and moisture read
  logic [30:0]      mem [MAX_CELLS];
  logic [30:0]      rd_q;
  logic             a_v_q;
  logic [IDX_W-1:0] a_idx_q;
  logic             a_cmd_q;
  logic [30:0]      a_pnet_q, a_sd_q, a_snacc_q, a_snm_q, a_rdep_q;
  logic [31:0]      a_tmax_q, a_tmin_q, a_tsoil_q;
  logic [16:0]      a_por_q, a_initf_q, a_fcap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (adv) begin
      a_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q      <= mem[counter_q];
      a_idx_q   <= counter_q;
      a_cmd_q   <= command_i;
      a_pnet_q  <= net_precip_i;
      a_tmax_q  <= temp_max_i;
      a_tmin_q  <= temp_min_i;
      a_sd_q    <= depression_storage_i;
      a_snacc_q <= snow_accum_i;
      a_snm_q   <= snow_melt_i;
      a_tsoil_q <= soil_temp_i;
      a_por_q   <= porosity_i;
      a_rdep_q  <= root_depth_i;
      a_initf_q <= init_fraction_i;
      a_fcap_q  <= field_capacity_i;
    end
  end

  assign a_hit  = a_v_q && (a_idx_q == counter_q);
  assign hazard = a_hit || calc_hit || div_hit;

  logic             c_v;
  logic [IDX_W-1:0] c_idx;
  logic [46:0]      c_dividend;
  erc_side_t        c_side;

  erc_calc #(.IDX_W(IDX_W)) u_calc (
    .clk_i, .rst_ni,
    .adv_i                (adv),
    .a_v_i                (a_v_q),
    .a_idx_i              (a_idx_q),
    .cmd_i                (a_cmd_q),
    .net_precip_i         (a_pnet_q),
    .temp_max_i           (a_tmax_q),
    .temp_min_i           (a_tmin_q),
    .depression_storage_i (a_sd_q),
    .snow_accum_i         (a_snacc_q),
    .snow_melt_i          (a_snm_q),
    .soil_temp_i          (a_tsoil_q),
    .porosity_i           (a_por_q),
    .root_depth_i         (a_rdep_q),
    .init_fraction_i      (a_initf_q),
    .field_capacity_i     (a_fcap_q),
    .stored_moist_i       (rd_q),
    .snow_temp_i          (snow_temp_q),
    .rain_snow_temp_i     (rain_snow_temp_q),
    .frozen_temp_i        (frozen_temp_q),
    .frozen_fraction_i    (frozen_fraction_q),
    .cmp_idx_i            (counter_q),
    .hit_o                (calc_hit),
    .v_o                  (c_v),
    .idx_o                (c_idx),
    .dividend_o           (c_dividend),
    .side_o               (c_side)
  );

  logic                d_v;
  logic [IDX_W-1:0]    d_idx;
  logic [QuotBits-1:0] d_quot;
  erc_side_t           d_side;

  erc_div #(.IDX_W(IDX_W)) u_div (
    .clk_i, .rst_ni,
    .adv_i      (adv),
    .v_i        (c_v),
    .idx_i      (c_idx),
    .dividend_i (c_dividend),
    .side_i     (c_side),
    .cmp_idx_i  (counter_q),
    .hit_o      (div_hit),
    .v_o        (d_v),
    .idx_o      (d_idx),
    .quot_o     (d_quot),
    .side_o     (d_side)
  );

  // moisture update never exceeds porosity, so no saturation here
  logic [30:0] new_moist;
  assign new_moist = d_side.moist + 31'(d_quot);

  always_ff @(posedge clk_i) begin
    if (adv && d_v) begin
      mem[d_idx] <= new_moist;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= d_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cell_index_o    <= 10'(d_idx);
      excess_precip_o <= d_side.excess;
      infiltration_o  <= d_side.infil;
      soil_moisture_o <= new_moist;
    end
  end

endmodule
`default_nettype wire

>>> design/erc_calc.sv
`timescale 1ns / 1ps
`default_nettype none
module erc_calc
  import erc_pkg::*;
#(
  parameter int unsigned IDX_W = 10
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               adv_i,
  input  wire logic               a_v_i,
  input  wire logic [IDX_W-1:0]   a_idx_i,
  input  wire logic               cmd_i,
  input  wire logic [30:0]        net_precip_i,
  input  wire logic signed [31:0] temp_max_i,
  input  wire logic signed [31:0] temp_min_i,
  input  wire logic [30:0]        depression_storage_i,
  input  wire logic [30:0]        snow_accum_i,
  input  wire logic [30:0]        snow_melt_i,
  input  wire logic signed [31:0] soil_temp_i,
  input  wire logic [16:0]        porosity_i,
  input  wire logic [30:0]        root_depth_i,
  input  wire logic [16:0]        init_fraction_i,
  input  wire logic [16:0]        field_capacity_i,
  input  wire logic [30:0]        stored_moist_i,
  input  wire logic signed [31:0] snow_temp_i,
  input  wire logic signed [31:0] rain_snow_temp_i,
  input  wire logic signed [31:0] frozen_temp_i,
  input  wire logic [16:0]        frozen_fraction_i,
  input  wire logic [IDX_W-1:0]   cmp_idx_i,
  output logic                    hit_o,
  output logic                    v_o,
  output logic [IDX_W-1:0]        idx_o,
  output logic [46:0]             dividend_o,
  output erc_side_t               side_o
);

  // stage A combinational
  logic signed [32:0] tsum;
  logic               no_water_gate;
  logic [32:0]        psum;
  logic [33:0]        init_prod;
  logic [30:0]        moist_a;
  logic [33:0]        frz_prod;
  logic               frz_a;

  always_comb begin
    tsum = 33'(temp_max_i) + 33'(temp_min_i);
    no_water_gate = (tsum <= 33'(snow_temp_i)) ||
                    ((tsum <= 33'(rain_snow_temp_i)) && (snow_accum_i > net_precip_i));
    psum = 33'(net_precip_i) + 33'(depression_storage_i) + 33'(snow_melt_i);
    init_prod = 34'(init_fraction_i) * 34'(field_capacity_i);
    moist_a = (cmd_i == CmdInit) ? 31'(init_prod[33:16]) : stored_moist_i;
    frz_prod = 34'(frozen_fraction_i) * 34'(porosity_i);
    frz_a = (soil_temp_i <= frozen_temp_i) && ({moist_a, 16'b0} >= 47'(frz_prod));
  end

  logic             b_v_q;
  logic [IDX_W-1:0] b_idx_q;
  logic             b_cmd_q;
  logic [31:0]      b_pe_q;
  logic [32:0]      b_p_q;
  logic             b_blk_q;
  logic [30:0]      b_moist_q;
  logic [16:0]      b_por_q;
  logic [30:0]      b_rdep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (adv_i) begin
      b_v_q <= a_v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      b_idx_q   <= a_idx_i;
      b_cmd_q   <= cmd_i;
      b_pe_q    <= 32'(net_precip_i) + 32'(snow_melt_i);
      b_p_q     <= no_water_gate ? 33'd0 : psum;
      b_blk_q   <= frz_a || (moist_a > 31'(porosity_i));
      b_moist_q <= moist_a;
      b_por_q   <= porosity_i;
      b_rdep_q  <= root_depth_i;
    end
  end

  // stage B: root-zone room
  logic [16:0] diff_b;
  logic [47:0] room_prod;

  always_comb begin
    diff_b = b_por_q - b_moist_q[16:0];
    room_prod = 48'(b_rdep_q) * 48'(diff_b);
  end

  logic             c_v_q;
  logic [IDX_W-1:0] c_idx_q;
  logic             c_cmd_q;
  logic [31:0]      c_pe_q;
  logic [32:0]      c_p_q;
  logic             c_blk_q;
  logic [30:0]      c_moist_q;
  logic [30:0]      c_rdep_q;
  logic [31:0]      c_room_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (adv_i) begin
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      c_idx_q   <= b_idx_q;
      c_cmd_q   <= b_cmd_q;
      c_pe_q    <= b_pe_q;
      c_p_q     <= b_p_q;
      c_blk_q   <= b_blk_q;
      c_moist_q <= b_moist_q;
      c_rdep_q  <= b_rdep_q;
      c_room_q  <= room_prod[47:16];
    end
  end

  // stage C: infiltration, excess, branch select
  logic [32:0]        infil_raw;
  logic [30:0]        infil_c;
  logic signed [33:0] exc_wide;
  logic [31:0]        exc_sat;
  logic [31:0]        pe_sat;

  always_comb begin
    if (c_room_q == 32'd0) begin
      infil_raw = 33'd0;
    end else if (c_p_q < 33'(c_room_q)) begin
      infil_raw = c_p_q;
    end else begin
      infil_raw = 33'(c_room_q);
    end
    infil_c = (infil_raw > 33'h07FFF_FFFF) ? 31'h7FFF_FFFF : infil_raw[30:0];
    exc_wide = $signed(34'(c_pe_q)) - $signed(34'(infil_c));
    if (exc_wide > 34'sh0_7FFF_FFFF) begin
      exc_sat = 32'h7FFF_FFFF;
    end else if (exc_wide < -34'sh0_8000_0000) begin
      exc_sat = 32'h8000_0000;
    end else begin
      exc_sat = exc_wide[31:0];
    end
    pe_sat = c_pe_q[31] ? 32'h7FFF_FFFF : c_pe_q;

    side_o.moist   = c_moist_q;
    side_o.divisor = c_rdep_q;
    if ((c_cmd_q == CmdInit) || (c_p_q == 33'd0)) begin
      side_o.excess = 32'd0;
      side_o.infil  = 31'd0;
      side_o.en     = 1'b0;
    end else if (c_blk_q) begin
      side_o.excess = pe_sat;
      side_o.infil  = 31'd0;
      side_o.en     = 1'b0;
    end else begin
      side_o.excess = exc_sat;
      side_o.infil  = infil_c;
      side_o.en     = (c_rdep_q != 31'd0);
    end
    dividend_o = {side_o.infil, 16'b0};
  end

  assign v_o   = c_v_q;
  assign idx_o = c_idx_q;
  assign hit_o = (b_v_q && (b_idx_q == cmp_idx_i)) || (c_v_q && (c_idx_q == cmp_idx_i));

endmodule
`default_nettype wire

>>> design/erc_div.sv
`timescale 1ns / 1ps
`default_nettype none
module erc_div
  import erc_pkg::*;
#(
  parameter int unsigned IDX_W = 10
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             adv_i,
  input  wire logic             v_i,
  input  wire logic [IDX_W-1:0] idx_i,
  input  wire logic [46:0]      dividend_i,
  input  wire erc_side_t        side_i,
  input  wire logic [IDX_W-1:0] cmp_idx_i,
  output logic                  hit_o,
  output logic                  v_o,
  output logic [IDX_W-1:0]      idx_o,
  output logic [QuotBits-1:0]   quot_o,
  output erc_side_t             side_o
);

  // one quotient bit per stage, most significant first
  logic             v_q    [QuotBits];
  logic [IDX_W-1:0] idx_q  [QuotBits];
  logic [46:0]      rem_q  [QuotBits];
  logic [QuotBits-1:0] quot_q [QuotBits];
  erc_side_t        side_q [QuotBits];

  for (genvar s = 0; s < QuotBits; s++) begin : g_stage
    localparam int unsigned Bit = QuotBits - 1 - s;
    logic [46:0]          rem_in;
    logic [QuotBits-1:0]  quot_in;
    logic [47:0]          trial;
    logic                 v_in;
    logic [IDX_W-1:0]     idx_in;
    erc_side_t            side_in;

    if (s == 0) begin : g_first
      assign rem_in  = dividend_i;
      assign quot_in = '0;
      assign v_in    = v_i;
      assign idx_in  = idx_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign quot_in = quot_q[s-1];
      assign v_in    = v_q[s-1];
      assign idx_in  = idx_q[s-1];
      assign side_in = side_q[s-1];
    end

    assign trial = {1'b0, rem_in} - (48'(side_in.divisor) << Bit);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (adv_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        idx_q[s]  <= idx_in;
        side_q[s] <= side_in;
        if (!trial[47]) begin
          rem_q[s]  <= trial[46:0];
          quot_q[s] <= quot_in | (QuotBits'(1) << Bit);
        end else begin
          rem_q[s]  <= rem_in;
          quot_q[s] <= quot_in;
        end
      end
    end
  end

  always_comb begin
    hit_o = 1'b0;
    for (int unsigned s = 0; s < QuotBits; s++) begin
      hit_o = hit_o | (v_q[s] && (idx_q[s] == cmp_idx_i));
    end
  end

  assign v_o    = v_q[QuotBits-1];
  assign idx_o  = idx_q[QuotBits-1];
  assign side_o = side_q[QuotBits-1];
  assign quot_o = side_q[QuotBits-1].en ? quot_q[QuotBits-1] : '0;

endmodule
`default_nettype wire

>>> design/erc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module erc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        pready,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [9:0]  cell_index_o,
  input wire logic [31:0] excess_precip_o,
  input wire logic [30:0] infiltration_o,
  input wire logic [30:0] soil_moisture_o
);

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(cell_index_o) &&
    $stable(excess_precip_o) && $stable(infiltration_o) && $stable(soil_moisture_o))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk_i) pready)
    else $error("pready low");

endmodule

bind excess_runoff_cell_step_top erc_checker u_erc_checker (
  .clk_i, .rst_ni, .pready, .out_valid_o, .out_stall_i, .cell_index_o,
  .excess_precip_o, .infiltration_o, .soil_moisture_o
);
`default_nettype wire

>>> tb/cell_step_checker.sv
`timescale 1ns / 1ps
module cell_step_checker
  import erc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               in_valid_i,
  input  logic               in_stall_o,
  input  logic               command_i,
  input  logic [30:0]        net_precip_i,
  input  logic signed [31:0] temp_max_i,
  input  logic signed [31:0] temp_min_i,
  input  logic [30:0]        depression_storage_i,
  input  logic [30:0]        snow_accum_i,
  input  logic [30:0]        snow_melt_i,
  input  logic signed [31:0] soil_temp_i,
  input  logic [16:0]        porosity_i,
  input  logic [30:0]        root_depth_i,
  input  logic [16:0]        init_fraction_i,
  input  logic [16:0]        field_capacity_i,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  logic [9:0]         cell_index_o,
  input  logic signed [31:0] excess_precip_o,
  input  logic [30:0]        infiltration_o,
  input  logic [30:0]        soil_moisture_o,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o
);

  typedef struct {
    logic [9:0]  cell_id;
    logic [31:0] excess;
    logic [30:0] infil;
    logic [30:0] moist;
  } cell_result_t;

  localparam logic [63:0] Max31 = 64'h7FFF_FFFF;

  logic signed [31:0] snow_temp, rain_snow_temp, frozen_temp;
  logic [16:0]        frozen_frac;
  logic [10:0]        cell_count;
  logic [30:0]        moisture[1024];
  logic [9:0]         cell_cnt;
  cell_result_t       expected_cells[$];

  function automatic logic [63:0] clip31(input logic [63:0] v);
    return (v > Max31) ? Max31 : v;
  endfunction

  task automatic predict_cell();
    logic [63:0]  pnet, sd, snacc, snm, por, rdep, moist, precip, room, infil;
    longint       tsum, excess;
    logic         frozen;
    logic [10:0]  nxt;
    cell_result_t r;
    pnet   = 64'(net_precip_i);
    sd     = 64'(depression_storage_i);
    snacc  = 64'(snow_accum_i);
    snm    = 64'(snow_melt_i);
    por    = 64'(porosity_i);
    rdep   = 64'(root_depth_i);
    moist  = 64'(moisture[cell_cnt]);
    excess = 0;
    infil  = 0;
    if (command_i == CmdInit) begin
      moist = clip31((64'(init_fraction_i) * 64'(field_capacity_i)) >> 16);
    end else begin
      tsum = longint'(temp_max_i) + longint'(temp_min_i);
      if (tsum <= longint'(snow_temp)) precip = 0;
      else if (tsum <= longint'(rain_snow_temp) && snacc > pnet) precip = 0;
      else precip = pnet + sd + snm;
      if (precip != 0) begin
        frozen = (longint'(soil_temp_i) <= longint'(frozen_temp)) &&
                 ((moist << 16) >= 64'(frozen_frac) * por);
        if (frozen || moist > por) begin
          excess = longint'(pnet + snm);
        end else begin
          room   = (rdep * (por - moist)) >> 16;
          infil  = clip31((room == 0) ? 0 : ((precip < room) ? precip : room));
          excess = longint'(pnet + snm) - longint'(infil);
          if (rdep != 0) moist = clip31(moist + ((infil << 16) / rdep));
        end
        if (excess > 64'sd2147483647) excess = 64'sd2147483647;
        if (excess < -64'sd2147483648) excess = -64'sd2147483648;
      end
    end
    moisture[cell_cnt] = moist[30:0];
    r.cell_id = cell_cnt;
    r.excess  = excess[31:0];
    r.infil   = infil[30:0];
    r.moist   = moist[30:0];
    expected_cells.push_back(r);
    nxt = 11'(cell_cnt) + 11'd1;
    cell_cnt = (nxt >= cell_count || nxt >= 11'd1024) ? 10'd0 : nxt[9:0];
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cell_result_t e;
    if (!rst_ni) begin
      snow_temp      = 32'sd0;
      rain_snow_temp = 32'sd65536;
      frozen_temp    = -32'sd327680;
      frozen_frac    = 17'd32768;
      cell_count     = 11'd1024;
      cell_cnt       = '0;
      expected_cells.delete();
      fail_count_o   = 0;
      checked_o      = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          RegSnowTemp:     snow_temp = pwdata;
          RegRainSnowTemp: rain_snow_temp = pwdata;
          RegFrozenTemp:   frozen_temp = pwdata;
          RegFrozenFrac:   frozen_frac = pwdata[16:0];
          RegCellCount:    cell_count = pwdata[10:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) predict_cell();
      if (out_valid_o && !out_stall_i) begin
        checked_o++;
        if (expected_cells.size() == 0) begin
          $error("result for cell %0d with no transaction outstanding", cell_index_o);
          fail_count_o++;
        end else begin
          e = expected_cells.pop_front();
          if (cell_index_o !== e.cell_id) begin
            $error("cell_index: expected %0d, got %0d", e.cell_id, cell_index_o);
            fail_count_o++;
          end
          if (excess_precip_o !== e.excess) begin
            $error("excess_precip: expected %0d, got %0d", $signed(e.excess),
                   excess_precip_o);
            fail_count_o++;
          end
          if (infiltration_o !== e.infil) begin
            $error("infiltration: expected %0d, got %0d", e.infil, infiltration_o);
            fail_count_o++;
          end
          if (soil_moisture_o !== e.moist) begin
            $error("soil_moisture: expected %0d, got %0d", e.moist, soil_moisture_o);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = expected_cells.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import erc_pkg::*;

  localparam int QuietLimit = 20000;
  localparam logic CmdStep = ~CmdInit;

  typedef struct {
    logic        cmd;
    logic [30:0] net, sd, snacc, snm, root;
    logic [31:0] tmax, tmin, tsoil;
    logic [16:0] por, initf, fcap;
  } cell_item_t;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic command_i;
  logic [30:0] net_precip_i, depression_storage_i, snow_accum_i, snow_melt_i;
  logic [30:0] root_depth_i;
  logic signed [31:0] temp_max_i, temp_min_i, soil_temp_i;
  logic [16:0] porosity_i, init_fraction_i, field_capacity_i;
  logic [9:0]  cell_index_o;
  logic signed [31:0] excess_precip_o;
  logic [30:0] infiltration_o, soil_moisture_o;

  int fail_count, pending, checked;
  int send_idle_pct, stall_pct, hold_left, quiet, sent, settings;
  logic [9:0]  cell_cnt;
  logic [10:0] wrap_at;
  logic        cell_ready[1024];

  excess_runoff_cell_step_top u_top (.*);

  cell_step_checker u_checker (
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked), .*
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // receiver: random stall plus a long hold-off while hold_left counts down
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QuietLimit) begin
        $display("** excess_runoff_cell_step_top: FAILED **");
        $finish;
      end
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // wait on the clock first so the last accepted transaction is already counted
  task automatic wait_drained();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic set_thresholds(input logic [31:0] snow, input logic [31:0] rain,
                                input logic [31:0] frz, input logic [16:0] frac,
                                input logic [10:0] cells);
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (30) @(posedge clk_i);
    reg_write(RegSnowTemp, snow);
    reg_write(RegRainSnowTemp, rain);
    reg_write(RegFrozenTemp, frz);
    reg_write(RegFrozenFrac, 32'(frac));
    reg_write(RegCellCount, 32'(cells));
    wrap_at = cells;
    settings++;
  endtask

  task automatic send_cell(input cell_item_t it);
    logic [10:0] nxt;
    // never step a cell whose moisture was not loaded yet
    if (!cell_ready[cell_cnt]) it.cmd = CmdInit;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    command_i            <= it.cmd;
    net_precip_i         <= it.net;
    temp_max_i           <= it.tmax;
    temp_min_i           <= it.tmin;
    depression_storage_i <= it.sd;
    snow_accum_i         <= it.snacc;
    snow_melt_i          <= it.snm;
    soil_temp_i          <= it.tsoil;
    porosity_i           <= it.por;
    root_depth_i         <= it.root;
    init_fraction_i      <= it.initf;
    field_capacity_i     <= it.fcap;
    in_valid_i           <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
    if (it.cmd == CmdInit) cell_ready[cell_cnt] = 1'b1;
    nxt = 11'(cell_cnt) + 11'd1;
    cell_cnt = (nxt >= wrap_at || nxt >= 11'd1024) ? 10'd0 : nxt[9:0];
  endtask

  function automatic cell_item_t plain_cell(input logic cmd);
    cell_item_t it;
    it.cmd   = cmd;
    it.net   = 31'(2 << 16);
    it.tmax  = 32'(10 << 16);
    it.tmin  = 32'(10 << 16);
    it.sd    = '0;
    it.snacc = '0;
    it.snm   = '0;
    it.tsoil = 32'(5 << 16);
    it.por   = 17'd26214;
    it.root  = 31'(100 << 16);
    it.initf = 17'd32768;
    it.fcap  = 17'd26214;
    return it;
  endfunction

  function automatic logic [30:0] pick31(input int unsigned typ);
    if ($urandom_range(3) == 0) return 31'($urandom);
    return 31'($urandom_range(typ, 0));
  endfunction

  function automatic logic [31:0] pick_temp();
    if ($urandom_range(3) == 0) return $urandom;
    return 32'($urandom_range(80 << 16, 0)) - 32'(40 << 16);
  endfunction

  function automatic logic [16:0] pick_frac();
    if ($urandom_range(4) == 0) return 17'($urandom);
    return 17'($urandom_range(65536, 0));
  endfunction

  function automatic cell_item_t random_cell();
    cell_item_t it;
    it.cmd   = ($urandom_range(4) == 0) ? CmdInit : CmdStep;
    it.net   = pick31(20 << 16);
    it.tmax  = pick_temp();
    it.tmin  = pick_temp();
    it.sd    = pick31(5 << 16);
    it.snacc = ($urandom_range(1) == 0) ? 31'd0 : pick31(30 << 16);
    it.snm   = ($urandom_range(1) == 0) ? 31'd0 : pick31(10 << 16);
    it.tsoil = pick_temp();
    it.por   = pick_frac();
    it.root  = ($urandom_range(4) == 0) ? 31'($urandom_range(32'h7FFF_FFFF, 1))
                                        : 31'($urandom_range(2000 << 16, 1));
    it.initf = pick_frac();
    it.fcap  = pick_frac();
    return it;
  endfunction

  task automatic random_phase(input int count, input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 46; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 46; end
      default: begin send_idle_pct = 23; stall_pct = 23; end
    endcase
    for (int i = 0; i < count; i++) send_cell(random_cell());
  endtask

  initial begin
    cell_item_t it;
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid_i = 1'b0; out_stall_i = 1'b0;
    it = plain_cell(CmdInit);
    command_i = it.cmd; net_precip_i = it.net; temp_max_i = it.tmax;
    temp_min_i = it.tmin; depression_storage_i = it.sd; snow_accum_i = it.snacc;
    snow_melt_i = it.snm; soil_temp_i = it.tsoil; porosity_i = it.por;
    root_depth_i = it.root; init_fraction_i = it.initf; field_capacity_i = it.fcap;
    send_idle_pct = 0; stall_pct = 0; hold_left = 0; quiet = 0;
    sent = 0; settings = 0; cell_cnt = '0; wrap_at = 11'd1024;
    foreach (cell_ready[i]) cell_ready[i] = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: four cells, default thresholds
    set_thresholds(32'sd0, 32'sd65536, -32'sd327680, 17'd32768, 11'd4);
    it = plain_cell(CmdInit); it.initf = 17'd65536; it.fcap = 17'd65536; send_cell(it);
    it = plain_cell(CmdInit); it.initf = 17'd0; send_cell(it);
    it = plain_cell(CmdInit); it.initf = '1; it.fcap = '1; send_cell(it);
    send_cell(plain_cell(CmdInit));
    // saturated soil with excess clipping at the top
    it = plain_cell(CmdStep); it.net = '1; it.snm = '1; send_cell(it);
    // snow gate at the coldest temperatures
    it = plain_cell(CmdStep); it.tmax = 32'h8000_0000; it.tmin = 32'h8000_0000;
    send_cell(it);
    // frozen soil
    it = plain_cell(CmdStep); it.tsoil = 32'h8000_0000; it.por = '1; send_cell(it);
    // rain on snow
    it = plain_cell(CmdStep); it.tmax = '0; it.tmin = 32'd32768; it.snacc = '1;
    send_cell(it);
    // no room left in the root zone
    it = plain_cell(CmdStep); it.tmax = 32'h7FFF_FFFF; it.tmin = 32'h7FFF_FFFF;
    it.por = 17'd65536; send_cell(it);
    // shallowest root zone
    it = plain_cell(CmdStep); it.por = 17'd65536; it.root = 31'd1; send_cell(it);
    it = plain_cell(CmdInit); it.initf = '0; it.fcap = '0; send_cell(it);
    // deepest root zone, room limits infiltration
    it = plain_cell(CmdStep); it.por = 17'd65536; it.root = '1; it.net = '1;
    it.sd = '1; send_cell(it);
    it = plain_cell(CmdStep); it.tsoil = 32'h7FFF_FFFF; it.snacc = '1;
    it.sd = '1; it.tmax = 32'h7FFF_FFFF; send_cell(it);
    // no water at all
    it = plain_cell(CmdStep); it.net = '0; send_cell(it);
    it = plain_cell(CmdStep); it.snm = 31'(3 << 16); it.por = 17'd65536; send_cell(it);
    it = plain_cell(CmdStep); it.por = '0; send_cell(it);

    set_thresholds(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 17'd0, 11'd1);
    random_phase(125, 1);
    set_thresholds(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 17'd65536, 11'd1024);
    random_phase(125, 2);
    set_thresholds(32'sd0, 32'sd65536, -32'sd327680, 17'd32768, 11'd7);
    // long receiver hold-off while items keep coming
    hold_left = 400;
    random_phase(125, 0);
    set_thresholds(-32'sd65536, 32'sd131072, 32'sd0, 17'd49152, 11'd32);
    random_phase(60, 3);
    in_valid_i <= 1'b0;
    wait_drained();
    random_phase(65, 3);
    set_thresholds(32'sd0, 32'sd65536, -32'sd327680, 17'd32768, 11'd3);
    random_phase(125, 0);
    set_thresholds($urandom, $urandom, $urandom, 17'($urandom_range(65536, 0)),
                   11'($urandom_range(64, 2)));
    random_phase(125, 1);

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (40) @(posedge clk_i);
    $display("covered %0d transactions, %0d results checked, over %0d register settings",
             sent, checked, settings);
    $display("with init and step mixed, cell counts from 1 to 1024 and four idling mixes");
    if (fail_count == 0) begin
      $display("** excess_runoff_cell_step_top: PASSED **");
    end else begin
      $display("** excess_runoff_cell_step_top: FAILED **");
    end
    $finish;
  end

endmodule

>>> excess_runoff_cell_step_top.f
design/erc_pkg.sv
design/erc_calc.sv
design/erc_div.sv
design/excess_runoff_cell_step_top.sv
design/erc_checker.sv
tb/cell_step_checker.sv
tb/tb.sv
